// ----- design/srcd_pkg.sv -----
`default_nettype none
package srcd_pkg;

  localparam int SRCD_MAX_STAGES = 4;
  localparam int STG_W = 3;
  localparam int PADDR_W = 3;
  localparam logic [7:0] BYTE_ONES = 8'd255;
  localparam logic [7:0] BYTE_ZEROS = 8'd0;
  localparam logic [STG_W-1:0] CHAIN_LEN_RST = 3'd4;

  typedef enum logic [2:0] {
    MODE_SET_PIN    = 3'd0,
    MODE_WRITE_BYTE = 3'd1,
    MODE_FILL_HIGH  = 3'd2,
    MODE_FILL_LOW   = 3'd3,
    MODE_READ_PIN   = 3'd4,
    MODE_REFRESH    = 3'd5
  } mode_t;

  localparam logic [1:0] KIND_BIT   = 2'd0;
  localparam logic [1:0] KIND_LATCH = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic REG_CHAIN_LEN = 1'b0;

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] pin_index;
    logic       pin_value;
    logic [1:0] byte_index;
    logic [7:0] byte_value;
    logic       refresh;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       serial_bit;
    logic       pin_state;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       shift;
    logic       wr_byte;
    logic [7:0] byte_val;
    logic       wr_bit;
    logic [2:0] bit_pos;
    logic       bit_val;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_LATCH = 3'b100
  } state_t;

endpackage
`default_nettype wire

// ----- design/srcd_cell.sv -----
`default_nettype none
module srcd_cell
  import srcd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       bit_in,
  output logic [7:0]      byte_out
);

  logic [7:0] img_r;
  logic [7:0] img_nxt;

  always_comb begin
    img_nxt = img_r;
    if (ctrl.shift) begin
      img_nxt = {img_r[6:0], bit_in};
    end else if (ctrl.wr_byte) begin
      img_nxt = ctrl.byte_val;
    end else if (ctrl.wr_bit) begin
      img_nxt[ctrl.bit_pos] = ctrl.bit_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_r <= BYTE_ZEROS;
    end else begin
      img_r <= img_nxt;
    end
  end

  assign byte_out = img_r;

endmodule
`default_nettype wire

// ----- design/shift_register_chain_driver.sv -----
`default_nettype none
// Refresh, fill, or set/write with refresh: 8*n serial-bit results then one latch,
// first result registered through state_r and out_strobe_r, one result per cycle; busy in ST_SHIFT and ST_LATCH.
// Read pin: one result the cycle after start, next transaction taken at once.
// Set/write without refresh: written on acceptance, no result. Rate set by the one-bit-per-cycle
// rotation through the stage cells. Synchronous reset clears the image and sets n to 4.
module shift_register_chain_driver
  import srcd_pkg::*;
#(
  parameter int MAX_STAGES = SRCD_MAX_STAGES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_item_t           in_item,
  output logic                    out_strobe,
  output out_item_t               out_item,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int CNT_W = $clog2(8 * MAX_STAGES + 1);

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [STG_W-1:0]       chain_len_r;
  logic                   out_strobe_r, out_strobe_nxt;
  out_item_t              out_item_r, out_item_nxt;

  logic [7:0]             img [MAX_STAGES];
  cell_ctrl_t             ctrl [MAX_STAGES];
  logic                   cell_bit_in [MAX_STAGES];

  logic [STG_W-1:0]       n_eff;
  logic [STG_W-1:0]       pin_stage;
  logic [STG_W-1:0]       byte_stage;
  logic                   accept;
  logic                   pin_ok;
  logic                   is_fill;
  logic                   need_refresh;
  logic [7:0]             pin_byte;
  logic                   top_bit;
  logic                   shifting;

  assign n_eff = (chain_len_r > STG_W'(MAX_STAGES)) ? STG_W'(MAX_STAGES) : chain_len_r;
  assign pin_stage = STG_W'(in_item.pin_index[4:3]);
  assign byte_stage = STG_W'(in_item.byte_index);
  assign pin_ok = pin_stage < n_eff;
  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);
  assign shifting = (state_r == ST_SHIFT);
  assign is_fill = (in_item.mode == MODE_FILL_HIGH) || (in_item.mode == MODE_FILL_LOW);
  assign need_refresh = is_fill || (in_item.mode == MODE_REFRESH)
                     || (((in_item.mode == MODE_SET_PIN) || (in_item.mode == MODE_WRITE_BYTE))
                         && in_item.refresh);

  always_comb begin
    pin_byte = BYTE_ZEROS;
    top_bit = 1'b0;
    for (int i = 0; i < MAX_STAGES; i++) begin
      if (pin_stage == STG_W'(i)) begin
        pin_byte = img[i];
      end
      if (n_eff == STG_W'(i + 1)) begin
        top_bit = img[i][7];
      end
    end
  end

  for (genvar g = 0; g < MAX_STAGES; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign cell_bit_in[g] = top_bit;
    end else begin : g_rest
      assign cell_bit_in[g] = img[g-1][7];
    end

    always_comb begin
      ctrl[g].shift = shifting && (STG_W'(g) < n_eff);
      ctrl[g].wr_byte = accept && (STG_W'(g) < n_eff)
                     && (is_fill || ((in_item.mode == MODE_WRITE_BYTE)
                                     && (byte_stage == STG_W'(g))));
      ctrl[g].byte_val = (in_item.mode == MODE_FILL_HIGH) ? BYTE_ONES :
                         (in_item.mode == MODE_FILL_LOW) ? BYTE_ZEROS : in_item.byte_value;
      ctrl[g].wr_bit = accept && (in_item.mode == MODE_SET_PIN) && pin_ok
                    && (pin_stage == STG_W'(g));
      ctrl[g].bit_pos = in_item.pin_index[2:0];
      ctrl[g].bit_val = in_item.pin_value;
    end

    srcd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl[g]),
      .bit_in   (cell_bit_in[g]),
      .byte_out (img[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.mode == MODE_READ_PIN) begin
            out_strobe_nxt = 1'b1;
            out_item_nxt.kind = KIND_READ;
            out_item_nxt.serial_bit = 1'b0;
            out_item_nxt.pin_state = pin_ok && pin_byte[in_item.pin_index[2:0]];
            out_item_nxt.last = 1'b1;
          end else if (need_refresh) begin
            cnt_nxt = CNT_W'({n_eff, 3'b000});
            state_nxt = (n_eff == '0) ? ST_LATCH : ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        out_strobe_nxt = 1'b1;
        out_item_nxt.kind = KIND_BIT;
        out_item_nxt.serial_bit = top_bit;
        out_item_nxt.pin_state = 1'b0;
        out_item_nxt.last = 1'b0;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_LATCH;
        end
      end
      ST_LATCH: begin
        out_strobe_nxt = 1'b1;
        out_item_nxt.kind = KIND_LATCH;
        out_item_nxt.serial_bit = 1'b0;
        out_item_nxt.pin_state = 1'b0;
        out_item_nxt.last = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_strobe_r <= 1'b0;
      chain_len_r <= CHAIN_LEN_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (psel && penable && pwrite && (paddr[2] == REG_CHAIN_LEN)) begin
        chain_len_r <= pwdata[STG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item = out_item_r;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHAIN_LEN) ? {{(32 - STG_W){1'b0}}, chain_len_r} : 32'd0;

endmodule
`default_nettype wire
